// ----- rtl/core/wam_pkg.sv -----
// wam_pkg: sizes, types and the divider request/response structs
// shared by the windowed average block and its submodules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wam_pkg;

    localparam int WINDOW_DEPTH = 64;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;
    localparam int HELD_W   = 7;
    localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int WIN_RESET = (64 > WINDOW_DEPTH) ? WINDOW_DEPTH : 64;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ----- rtl/core/wam_if.sv -----
// wam_in_if / wam_out_if: valid-ready channels for samples and results
// depends on wam_pkg
`timescale 1ns / 1ps
`default_nettype none
interface wam_in_if;
    import wam_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wam_out_if;
    import wam_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] average;
    logic [HELD_W-1:0]          samples_held;

    modport source (output valid, output minimum, output maximum, output average,
                    output samples_held, input ready);
    modport sink   (input valid, input minimum, input maximum, input average,
                    input samples_held, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wam_ram.sv -----
// wam_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module wam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/wam_div.sv -----
// wam_div: bit-serial signed divider, sum over fill count, truncating toward zero
// depends on wam_pkg
`timescale 1ns / 1ps
`default_nettype none
module wam_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wam_pkg::t_div_req i_req,
    output wam_pkg::t_div_rsp      o_rsp
);
    import wam_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  signed_quo;

    // magnitude of the dividend; the most negative sum still fits unsigned
    assign mag = i_req.dividend[SUM_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;

    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign signed_quo     = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = signed_quo[SAMPLE_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/windowed_average_running_min_max.sv -----
// windowed_average_running_min_max: moving average over a sample ring with
// running min and max since clear; depends on wam_pkg, wam_if, wam_ram, wam_div
//
//  channel     | dir | handshake        | payload
//  ------------+-----+------------------+----------------------------------------
//  i_in        | in  | valid / ready    | sample (signed Q16.16)
//  o_out       | out | valid / ready    | minimum, maximum, average, samples_held
//  i_cfg_*     | in  | write enable     | window_size (7 bits), clears window state
//
//  one item at a time: accept, ring read, the shift steps and the done step of
//  the bit-serial divider, then the result is loaded into the output register
//  once that register is free
//  synchronous active-low reset; the ring needs no clearing pass
//  a held result in o_out does not block the next sample from being taken
`timescale 1ns / 1ps
`default_nettype none
module windowed_average_running_min_max (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [wam_pkg::CFG_W-1:0]   i_cfg_wdata,
    wam_in_if.sink                           i_in,
    wam_out_if.source                        o_out
);
    import wam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a sample
        S_READ = 4'b0010,   // ring data back, update sum and marks
        S_DIV  = 4'b0100,   // divider running
        S_OUT  = 4'b1000    // waiting for the output register
    } t_state;

    t_state r_state;

    // window state
    logic [CNT_W-1:0]           r_win;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SLOT_W-1:0]          r_slot;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_seen;
    logic signed [SAMPLE_W-1:0] r_low;
    logic signed [SAMPLE_W-1:0] r_high;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_avg;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_min;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic signed [SAMPLE_W-1:0] r_out_avg;
    logic [HELD_W-1:0]          r_out_held;

    logic                       accept;
    logic                       full;
    logic                       out_free;
    logic [SAMPLE_W-1:0]        ring_rdata;
    logic signed [SUM_W-1:0]    oldest;
    logic signed [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]           n_fill;
    logic [CNT_W-1:0]           slot_inc;
    logic [SLOT_W-1:0]          n_slot;
    logic [CMP_W-1:0]           cfg_ext;
    logic [CMP_W-1:0]           cfg_sat;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid & i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // window size saturates to 1..depth
    assign cfg_ext = CMP_W'(i_cfg_wdata);
    always_comb begin
        priority if (cfg_ext == '0) begin
            cfg_sat = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_DEPTH)) begin
            cfg_sat = CMP_W'(WINDOW_DEPTH);
        end else begin
            cfg_sat = cfg_ext;
        end
    end

    // sample ring: read the slot on accept, write the new sample into it from S_READ
    wam_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    // once the window is full the overwritten sample leaves the sum;
    // before that the slot was not written since the last clear and its data is ignored
    assign full     = (r_fill >= r_win);
    assign oldest   = full ? SUM_W'(signed'(ring_rdata)) : '0;
    assign n_sum    = r_sum - oldest + SUM_W'(r_sample);
    assign n_fill   = full ? r_fill : r_fill + 1'b1;
    assign slot_inc = CNT_W'(r_slot) + 1'b1;
    assign n_slot   = (slot_inc >= r_win) ? '0 : slot_inc[SLOT_W-1:0];

    assign div_req.start    = (r_state == S_READ);
    assign div_req.dividend = n_sum;
    assign div_req.divisor  = n_fill;

    wam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window state, cleared by reset and by a window size write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= CNT_W'(WIN_RESET);
            r_sum  <= '0;
            r_slot <= '0;
            r_fill <= '0;
            r_seen <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cfg_we) begin
            r_win  <= cfg_sat[CNT_W-1:0];
            r_sum  <= '0;
            r_slot <= '0;
            r_fill <= '0;
            r_seen <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
        end else if (r_state == S_READ) begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
            r_slot <= n_slot;
            r_seen <= 1'b1;
            // first sample sets both marks
            priority if (!r_seen) begin
                r_low  <= r_sample;
                r_high <= r_sample;
            end else if (r_sample < r_low) begin
                r_low  <= r_sample;
            end else if (r_sample > r_high) begin
                r_high <= r_sample;
            end else begin
                // sample between the marks, both stay
                r_low  <= r_low;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_avg <= div_rsp.quotient;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end else begin
                // result still waiting to be taken
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_min  <= r_low;
            r_out_max  <= r_high;
            r_out_avg  <= r_avg;
            r_out_held <= HELD_W'(r_fill);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.minimum      = r_out_min;
    assign o_out.maximum      = r_out_max;
    assign o_out.average      = r_out_avg;
    assign o_out.samples_held = r_out_held;
endmodule
`default_nettype wire

// ----- rtl/core/wam_checker.sv -----
// wam_checker: port-level assertions for windowed_average_running_min_max
// attached by bind; depends on wam_pkg
`timescale 1ns / 1ps
`default_nettype none
module wam_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_ready,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic signed [wam_pkg::SAMPLE_W-1:0] i_out_min,
    input wire logic signed [wam_pkg::SAMPLE_W-1:0] i_out_max,
    input wire logic [wam_pkg::HELD_W-1:0]      i_out_held
);
    import wam_pkg::*;

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // one item in flight: no back-to-back accepts
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    // every result covers at least one sample
    a_held_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_held != '0)
        else $error("result with empty window");

    // running marks stay ordered
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_min <= i_out_max)
        else $error("minimum above maximum");
endmodule

bind windowed_average_running_min_max wam_checker u_wam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_min   (o_out.minimum),
    .i_out_max   (o_out.maximum),
    .i_out_held  (o_out.samples_held)
);
`default_nettype wire

// ----- tb/wam_stats_checker.sv -----
// wam_stats_checker: watches the sample and result channels of the windowed
// average block, predicts every result and compares it field by field
// depends on wam_pkg and wam_if
`timescale 1ns / 1ps
module wam_stats_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wam_pkg::CFG_W-1:0] i_cfg_wdata,
    wam_in_if                         i_in_ch,
    wam_out_if                        i_out_ch,
    output int                        o_fail_count,
    output int                        o_outstanding
);
    import wam_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
        logic [SAMPLE_W-1:0] average;
        logic [HELD_W-1:0]   samples_held;
    } t_stats;

    // private copy of the block state
    logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
    logic signed [SUM_W-1:0]    run_sum;
    logic [SLOT_W-1:0]          slot_ptr;
    logic [CNT_W-1:0]           held;
    logic                       seen;
    logic signed [SAMPLE_W-1:0] lo_mark;
    logic signed [SAMPLE_W-1:0] hi_mark;
    logic [CMP_W-1:0]           win_len;

    t_stats expected_stats [$];
    int     fails;

    task automatic clear_window();
        run_sum  = '0;
        slot_ptr = '0;
        held     = '0;
        seen     = 1'b0;
        lo_mark  = '0;
        hi_mark  = '0;
    endtask

    task automatic set_length(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
        win_len = n[CMP_W-1:0];
        clear_window();
    endtask

    // fold one sample into the window and queue the stats it yields
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int     slot;
        longint quot;
        t_stats e;
        slot = int'(slot_ptr);
        if (slot >= int'(win_len)) slot = 0;
        if (int'(held) >= int'(win_len)) run_sum = run_sum - ring[slot];
        else held = held + 1'b1;
        ring[slot] = s;
        run_sum = run_sum + s;
        slot++;
        if (slot >= int'(win_len)) slot = 0;
        slot_ptr = slot[SLOT_W-1:0];
        if (!seen) begin
            lo_mark = s;
            hi_mark = s;
            seen    = 1'b1;
        end else if (s < lo_mark) begin
            lo_mark = s;
        end else if (s > hi_mark) begin
            hi_mark = s;
        end
        quot = longint'(run_sum) / longint'(held);
        e.minimum      = lo_mark;
        e.maximum      = hi_mark;
        e.average      = quot[SAMPLE_W-1:0];
        e.samples_held = held[HELD_W-1:0];
        expected_stats.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h actual %h", name, want, got);
            fails++;
        end
    endtask

    initial begin
        fails = 0;
        win_len = WIN_RESET[CMP_W-1:0];
        clear_window();
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (!i_rst_n) begin
            win_len = WIN_RESET[CMP_W-1:0];
            clear_window();
            expected_stats.delete();
        end else begin
            if (i_cfg_we) set_length(i_cfg_wdata);
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_stats.size() == 0) begin
                    $error("result with no sample waiting");
                    fails++;
                end else begin
                    e = expected_stats.pop_front();
                    check_field("minimum", e.minimum, i_out_ch.minimum);
                    check_field("maximum", e.maximum, i_out_ch.maximum);
                    check_field("average", e.average, i_out_ch.average);
                    check_field("samples_held", SAMPLE_W'(e.samples_held),
                                SAMPLE_W'(i_out_ch.samples_held));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) take_sample(i_in_ch.sample);
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_stats.size();
    end
endmodule

// ----- tb/windowed_average_running_min_max_test.sv -----
// windowed_average_running_min_max_test: drives samples and window writes into
// the block and gives the verdict; depends on wam_pkg, wam_if, the block and
// wam_stats_checker
`timescale 1ns / 1ps
module windowed_average_running_min_max_test;
    import wam_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off to back the block up
    localparam int SETTLE       = 8;      // idle cycles before a window write
    localparam int TAIL         = 100;    // idle cycles before the verdict
    localparam int LIMIT        = 500000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    bit               sender_calm;

    wam_in_if  in_ch ();
    wam_out_if out_ch ();

    always #5 clk = ~clk;

    windowed_average_running_min_max u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    wam_stats_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // offer one sample item after a random gap and wait until it is taken;
    // when the gap is zero valid simply stays high for the next item
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has come back;
    // one extra edge first so the checker count covers the last accepted item
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // window write, only ever issued while the block is idle
    task automatic set_window(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly legal lengths, with the ends and the saturating codes mixed in
    function automatic logic [CFG_W-1:0] pick_window();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 7'd1;
            1:       v = 7'd64;
            2:       v = 7'd0;                            // acts as one
            3:       v = 7'd127;                          // saturates to the depth
            4:       v = 7'($urandom_range(65, 127));
            5:       v = 7'($urandom_range(1, 4));
            default: v = 7'($urandom_range(1, 64));
        endcase
        return v;
    endfunction

    // sample shapes: raw random, small values near zero, extremes, ramps that
    // keep moving the min or max, and runs pinned at one rail for the sum ends
    function automatic logic signed [SAMPLE_W-1:0] make_sample(input int style,
                                                               input bit dir,
                                                               input int k);
        logic signed [SAMPLE_W-1:0] s;
        case (style)
            3: s = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            4: begin
                case ($urandom_range(0, 5))
                    0:       s = 32'sh7FFF_FFFF;
                    1:       s = 32'sh8000_0000;
                    2:       s = 32'sh0000_0000;
                    3:       s = -32'sd1;
                    4:       s = 32'sd1;
                    default: s = $urandom;
                endcase
            end
            5: s = (dir ? k : -k) * 32'sh0001_0000 + $signed($urandom_range(0, 255));
            6: s = dir ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    // result side: random stall after each item, calm stretches without
    // stalls, and two long hold-offs while the sender keeps offering
    initial begin : result_sink
        int  taken;
        int  gap;
        bit  calm;
        taken = 0;
        calm  = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                taken++;
                if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
                if (taken == 300 || taken == 1000) gap = HOLD_CYCLES;
                else gap = calm ? 0 : $urandom_range(0, 7);
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // hard stop if the block hangs
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int total;
        int n;
        int style;
        bit dir;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        rst_n        <= 1'b0;
        sender_calm  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of 64: first sample after clear sets both marks,
        // then both rails and the values around zero
        push_sample(32'sh0000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        push_sample(-32'sd1);
        push_sample(32'sd1);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        drain_results();

        // zero acts as a window of one: every item replaces the last
        set_window(7'd0);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        push_sample(-32'sd1);
        push_sample(32'sh0005_8000);
        drain_results();

        // an oversized write saturates to the full depth and clears the marks
        set_window(7'd127);
        push_sample(-32'sd7);
        push_sample(32'sd3);
        push_sample(32'sh8000_0000);
        drain_results();

        // short window that wraps a few times, odd sums that truncate
        set_window(7'd3);
        push_sample(32'sh0001_0000);
        push_sample(-32'sh0002_0001);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh7FFF_FFFF);
        push_sample(-32'sd1);
        push_sample(32'sh8000_0000);
        push_sample(32'sh8000_0000);
        push_sample(32'sd2);

        // random phases, each with a fresh window setting
        total = 0;
        while (total < RANDOM_ITEMS) begin
            drain_results();
            set_window(pick_window());
            n           = $urandom_range(10, 140);
            style       = $urandom_range(0, 7);
            dir         = $urandom_range(0, 1);
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) push_sample(make_sample(style, dir, k));
            total += n;
        end

        drain_results();
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
